// File: sv/tceu_pkg.sv
// Shared types and constants of the toy CPU execute unit.
// Beat structs, command and status codes, default sizes. No dependencies.
`default_nettype none

package tceu_pkg;

    // Default sizes handed to the top level parameters
    localparam int NUM_REGS_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Configuration register
    localparam int              CFG_W         = 5;
    localparam logic [CFG_W-1:0] REGS_IN_USE_RST = 5'd8;

    // Command codes
    localparam logic [4:0] CMD_MOV  = 5'd0;
    localparam logic [4:0] CMD_ADD  = 5'd1;
    localparam logic [4:0] CMD_SUB  = 5'd2;
    localparam logic [4:0] CMD_MUL  = 5'd3;
    localparam logic [4:0] CMD_DIV  = 5'd4;
    localparam logic [4:0] CMD_AND  = 5'd5;
    localparam logic [4:0] CMD_OR   = 5'd6;
    localparam logic [4:0] CMD_XOR  = 5'd7;
    localparam logic [4:0] CMD_TEST = 5'd8;
    localparam logic [4:0] CMD_CMP  = 5'd9;
    localparam logic [4:0] CMD_NOT  = 5'd10;
    localparam logic [4:0] CMD_INC  = 5'd11;
    localparam logic [4:0] CMD_DEC  = 5'd12;
    localparam logic [4:0] CMD_JE   = 5'd13;
    localparam logic [4:0] CMD_JNE  = 5'd14;
    localparam logic [4:0] CMD_JG   = 5'd15;
    localparam logic [4:0] CMD_JGE  = 5'd16;
    localparam logic [4:0] CMD_JL   = 5'd17;
    localparam logic [4:0] CMD_JLE  = 5'd18;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNK_REG = 2'd1;
    localparam logic [1:0] STAT_DIV0    = 2'd2;

    // Instruction beat
    typedef struct packed {
        logic [4:0]         cmd;
        logic [15:0]        dest_operand;
        logic               src_is_imm;
        logic signed [31:0] src_operand;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [1:0]         status;
        logic               jump_taken;
        logic [15:0]        jump_target;
        logic signed [31:0] flag_value;
    } t_out_beat;

    // Start request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctrl;

endpackage

`default_nettype wire

// File: sv/tceu_regfile.sv
// Register file: synchronous memory, two registered read ports, one write port.
// Per-entry valid bits make unwritten entries read as zero. Uses no package items.
`default_nettype none

module tceu_regfile #(
    parameter int NUM_REGS   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [$clog2(NUM_REGS)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(NUM_REGS)-1:0] i_rd_addr_b,
    output logic      [DATA_WIDTH-1:0]       o_rd_data_a,
    output logic      [DATA_WIDTH-1:0]       o_rd_data_b,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(NUM_REGS)-1:0] i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0]       i_wr_data
);

    logic [DATA_WIDTH-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   r_vld;
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;
    logic                  r_rd_va;
    logic                  r_rd_vb;

    // Storage write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    // Valid bits, cleared at reset; read valid follows the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_va <= 1'b0;
            r_rd_vb <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_va <= r_vld[i_rd_addr_a];
                r_rd_vb <= r_vld[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a = r_rd_va ? r_rd_a : '0;
    assign o_rd_data_b = r_rd_vb ? r_rd_b : '0;

endmodule

`default_nettype wire

// File: sv/tceu_muldiv.sv
// Shared iterative multiply/divide unit, one bit per cycle.
// Low-word product, or signed quotient truncated toward zero. Uses tceu_pkg::t_md_ctrl.
`default_nettype none

module tceu_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tceu_pkg::t_md_ctrl    i_ctrl,
    input  wire logic [DATA_WIDTH-1:0] i_op_a,
    input  wire logic [DATA_WIDTH-1:0] i_op_b,
    output logic                       o_done,
    output logic      [DATA_WIDTH-1:0] o_result
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic          r_is_div;
    logic          r_neg;
    logic [W-1:0]  r_acc;    // product accumulator
    logic [W-1:0]  r_mcand;  // shifted multiplicand
    logic [W-1:0]  r_quo;    // multiplier bits, or dividend shifting into quotient
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvs;    // divisor magnitude
    logic          r_done;
    logic [W-1:0]  r_result;

    logic [W-1:0]  w_mag_a;
    logic [W-1:0]  w_mag_b;
    logic [W:0]    w_rem_sh;
    logic [W:0]    w_diff;

    // Operand magnitudes and one restoring division step
    always_comb begin
        w_mag_a  = i_op_a[W-1] ? (~i_op_a + 1'b1) : i_op_a;
        w_mag_b  = i_op_b[W-1] ? (~i_op_b + 1'b1) : i_op_b;
        w_rem_sh = {r_rem, r_quo[W-1]};
        w_diff   = w_rem_sh - {1'b0, r_dvs};
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctrl.start) begin
                        r_is_div <= i_ctrl.is_div;
                        r_neg    <= i_op_a[W-1] ^ i_op_b[W-1];
                        r_cnt    <= CW'(W);
                        r_acc    <= '0;
                        r_rem    <= '0;
                        r_mcand  <= i_op_a;
                        r_dvs    <= w_mag_b;
                        r_quo    <= i_ctrl.is_div ? w_mag_a : i_op_b;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_is_div) begin
                        if (!w_diff[W]) begin
                            r_rem <= w_diff[W-1:0];
                            r_quo <= {r_quo[W-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rem_sh[W-1:0];
                            r_quo <= {r_quo[W-2:0], 1'b0};
                        end
                    end else begin
                        if (r_quo[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand <= {r_mcand[W-2:0], 1'b0};
                        r_quo   <= {1'b0, r_quo[W-1:1]};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // sign fix of the quotient; min / -1 wraps by itself
                    if (r_is_div) begin
                        r_result <= r_neg ? (~r_quo + 1'b1) : r_quo;
                    end else begin
                        r_result <= r_acc;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: sv/toy_cpu_execute_unit.sv
// Channel   Dir  Handshake            Payload
// in        in   i_in_valid/o_in_stall   tceu_pkg::t_in_beat (one instruction)
// out       out  o_out_valid/i_out_stall tceu_pkg::t_out_beat (one result)
// cfg       in   i_cfg_wr_en          i_cfg_wdata (regs_in_use)
//
// One instruction at a time: accept, register file read, execute, output load.
// Most commands go straight from execute to output load; mul and div wait in S_MULDIV
// for the bit-serial multiply/divide unit. Reset is synchronous and active low; the
// register file valid bits clear at once, so no clearing pass. A stalled output
// holds the finished result; the next instruction is taken once it is loaded.
//
// Top level of the execute unit. Depends on tceu_pkg, tceu_regfile, tceu_muldiv.
`default_nettype none

module toy_cpu_execute_unit #(
    parameter int NUM_REGS   = tceu_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = tceu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire tceu_pkg::t_in_beat         i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output tceu_pkg::t_out_beat             o_out_data,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [tceu_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int W     = DATA_WIDTH;
    localparam int AW    = $clog2(NUM_REGS);
    localparam int CNT_W = ($clog2(NUM_REGS + 1) > tceu_pkg::CFG_W) ?
                           $clog2(NUM_REGS + 1) : tceu_pkg::CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MULDIV,
        S_DONE
    } t_state;

    // State and registers
    t_state                      r_state,       n_state;
    logic [tceu_pkg::CFG_W-1:0]  r_regs_in_use;
    logic [4:0]                  r_cmd;
    logic [15:0]                 r_dest;
    logic                        r_imm;
    logic [W-1:0]                r_imm_val;
    logic                        r_dest_bad;
    logic                        r_src_bad;
    logic [W-1:0]                r_flag,        n_flag;
    logic [1:0]                  r_status,      n_status;
    logic                        r_taken,       n_taken;
    logic [15:0]                 r_target,      n_target;
    logic                        r_out_valid,   n_out_valid;
    tceu_pkg::t_out_beat         r_out_data,    n_out_data;

    // Datapath nets
    logic                        w_accept;
    logic [CNT_W-1:0]            w_count;
    logic signed [63:0]          w_imm_ext;
    logic signed [63:0]          w_flag_ext;
    logic [W-1:0]                w_rf_a;
    logic [W-1:0]                w_rf_b;
    logic [W-1:0]                w_src;
    logic                        w_zero;
    logic                        w_neg;
    logic                        w_cond;
    logic                        w_wr_en;
    logic [W-1:0]                w_wr_data;
    tceu_pkg::t_md_ctrl          w_md_ctrl;
    logic                        w_md_done;
    logic [W-1:0]                w_md_result;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Effective register count: regs_in_use limited to NUM_REGS
    assign w_count = (CNT_W'(r_regs_in_use) > CNT_W'(NUM_REGS)) ?
                     CNT_W'(NUM_REGS) : CNT_W'(r_regs_in_use);

    // Immediate sign-extended from 32 bits, then cut to the word
    assign w_imm_ext  = 64'(i_in_data.src_operand);
    assign w_flag_ext = 64'($signed(r_flag));

    tceu_regfile #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (i_in_data.dest_operand[AW-1:0]),
        .i_rd_addr_b (i_in_data.src_operand[AW-1:0]),
        .o_rd_data_a (w_rf_a),
        .o_rd_data_b (w_rf_b),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (r_dest[AW-1:0]),
        .i_wr_data   (w_wr_data)
    );

    tceu_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_md_ctrl),
        .i_op_a   (w_rf_a),
        .i_op_b   (w_src),
        .o_done   (w_md_done),
        .o_result (w_md_result)
    );

    // Source operand and jump condition
    always_comb begin
        w_src  = r_imm ? r_imm_val : w_rf_b;
        w_zero = (r_flag == '0);
        w_neg  = r_flag[W-1];
        case (r_cmd)
            tceu_pkg::CMD_JE:  w_cond = w_zero;
            tceu_pkg::CMD_JNE: w_cond = !w_zero;
            tceu_pkg::CMD_JG:  w_cond = !w_zero && !w_neg;
            tceu_pkg::CMD_JGE: w_cond = !w_neg;
            tceu_pkg::CMD_JL:  w_cond = w_neg;
            tceu_pkg::CMD_JLE: w_cond = w_zero || w_neg;
            default:           w_cond = 1'b0;
        endcase
    end

    // Execute step, write-back and output load
    always_comb begin
        n_state     = r_state;
        n_flag      = r_flag;
        n_status    = r_status;
        n_taken     = r_taken;
        n_target    = r_target;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_wr_en     = 1'b0;
        w_wr_data   = w_rf_a;
        w_md_ctrl   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_DONE;
                n_status = tceu_pkg::STAT_OK;
                n_taken  = 1'b0;
                n_target = '0;
                if (r_cmd inside {[tceu_pkg::CMD_JE:tceu_pkg::CMD_JLE]}) begin
                    n_taken  = w_cond;
                    n_target = w_cond ? r_dest : '0;
                end else if (r_cmd <= tceu_pkg::CMD_DEC) begin
                    if (r_dest_bad) begin
                        n_status = tceu_pkg::STAT_UNK_REG;
                    end else if (r_cmd inside {[tceu_pkg::CMD_NOT:tceu_pkg::CMD_DEC]}) begin
                        w_wr_en = 1'b1;
                        case (r_cmd)
                            tceu_pkg::CMD_NOT: w_wr_data = ~w_rf_a;
                            tceu_pkg::CMD_INC: w_wr_data = w_rf_a + 1'b1;
                            default:           w_wr_data = w_rf_a - 1'b1;
                        endcase
                    end else if (!r_imm && r_src_bad) begin
                        n_status = tceu_pkg::STAT_UNK_REG;
                    end else begin
                        case (r_cmd)
                            tceu_pkg::CMD_MOV: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_src;
                            end
                            tceu_pkg::CMD_ADD: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_rf_a + w_src;
                            end
                            tceu_pkg::CMD_SUB: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_rf_a - w_src;
                            end
                            tceu_pkg::CMD_MUL: begin
                                w_md_ctrl.start = 1'b1;
                                n_state         = S_MULDIV;
                            end
                            tceu_pkg::CMD_DIV: begin
                                if (w_src == '0) begin
                                    n_status = tceu_pkg::STAT_DIV0;
                                end else begin
                                    w_md_ctrl.start  = 1'b1;
                                    w_md_ctrl.is_div = 1'b1;
                                    n_state          = S_MULDIV;
                                end
                            end
                            tceu_pkg::CMD_AND: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_rf_a & w_src;
                            end
                            tceu_pkg::CMD_OR: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_rf_a | w_src;
                            end
                            tceu_pkg::CMD_XOR: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_rf_a ^ w_src;
                            end
                            tceu_pkg::CMD_TEST: begin
                                n_flag = w_rf_a & w_src;
                            end
                            default: begin
                                n_flag = w_rf_a - w_src;
                            end
                        endcase
                    end
                end
            end
            S_MULDIV: begin
                if (w_md_done) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = w_md_result;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_data.status      = r_status;
                    n_out_data.jump_taken  = r_taken;
                    n_out_data.jump_target = r_target;
                    n_out_data.flag_value  = w_flag_ext[31:0];
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Registers: control under reset, payload free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_regs_in_use <= tceu_pkg::REGS_IN_USE_RST;
            r_flag        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_regs_in_use <= i_cfg_wdata;
            end
        end
        if (w_accept) begin
            r_cmd      <= i_in_data.cmd;
            r_dest     <= i_in_data.dest_operand;
            r_imm      <= i_in_data.src_is_imm;
            r_imm_val  <= w_imm_ext[W-1:0];
            r_dest_bad <= (i_in_data.dest_operand >= 16'(w_count));
            r_src_bad  <= ($unsigned(i_in_data.src_operand) >= 32'(w_count));
        end
        r_status   <= n_status;
        r_taken    <= n_taken;
        r_target   <= n_target;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // No write-back for an out-of-range destination
    a_no_bad_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !r_dest_bad)
        else $error("register write to an unknown destination");

    // Writes only from the execute or multiply/divide steps
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_EXEC || r_state == S_MULDIV))
        else $error("register write outside execute");

    // Unit completion is only seen while waiting for it
    a_md_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == S_MULDIV))
        else $error("multiply/divide done while not waiting");

    // An accepted beat always goes to execute next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");
`endif

endmodule

`default_nettype wire
